>>> hdl/mbl_pkg.sv
// shared types and constants of the multichannel biquad lowpass unit
// no dependencies; used by mbl_mac and multichannel_biquad_lowpass_unit
package mbl_pkg;

    localparam int SAMPLE_W = 24;
    localparam int COEF_W   = 32;
    localparam int CH_W     = 3;
    localparam int CFG_AW   = 2;
    localparam int FRAC_W   = 28;
    localparam int ACC_W    = 60;

    typedef enum logic {
        OP_FILTER = 1'b0,
        OP_CLEAR  = 1'b1
    } t_opcode;

    typedef enum logic [CFG_AW-1:0] {
        REG_GAIN_A0     = 2'd0,
        REG_GAIN_A1     = 2'd1,
        REG_FEEDBACK_B1 = 2'd2,
        REG_FEEDBACK_B2 = 2'd3
    } t_cfg_index;

    // one channel's history as stored in the memory
    typedef struct packed {
        logic [SAMPLE_W-1:0] x1;
        logic [SAMPLE_W-1:0] x2;
        logic [SAMPLE_W-1:0] y1;
        logic [SAMPLE_W-1:0] y2;
    } t_hist;

    typedef struct packed {
        logic [COEF_W-1:0] a0;
        logic [COEF_W-1:0] a1;
        logic [COEF_W-1:0] b1;
        logic [COEF_W-1:0] b2;
    } t_coefs;

endpackage

>>> hdl/mbl_mac.sv
// multiply-accumulate pipeline of the biquad: products, pair sums, round and saturate
// depends on mbl_pkg; two register stages, result is combinational from the second
module mbl_mac (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [mbl_pkg::SAMPLE_W-1:0] i_x,
    input  mbl_pkg::t_hist                      i_hist,
    input  mbl_pkg::t_coefs                     i_coefs,
    output logic signed [mbl_pkg::SAMPLE_W-1:0] o_y
);

    localparam int P0_W  = mbl_pkg::SAMPLE_W + 1 + mbl_pkg::COEF_W;
    localparam int P_W   = mbl_pkg::SAMPLE_W + mbl_pkg::COEF_W;
    localparam int Q_W   = mbl_pkg::ACC_W - mbl_pkg::FRAC_W;
    localparam logic signed [mbl_pkg::ACC_W-1:0] ROUND_BIAS =
        mbl_pkg::ACC_W'(1) <<< (mbl_pkg::FRAC_W - 1);
    localparam logic signed [Q_W-1:0] SAT_MAX = Q_W'((1 << (mbl_pkg::SAMPLE_W - 1)) - 1);
    localparam logic signed [Q_W-1:0] SAT_MIN = -(Q_W'(1 << (mbl_pkg::SAMPLE_W - 1)));

    logic signed [mbl_pkg::SAMPLE_W:0]  xs;
    logic signed [P0_W-1:0]             m0;
    logic signed [P_W-1:0]              m1;
    logic signed [P_W-1:0]              m2;
    logic signed [P_W-1:0]              m3;
    logic signed [mbl_pkg::ACC_W-1:0]   r_p0;
    logic signed [mbl_pkg::ACC_W-1:0]   r_p1;
    logic signed [mbl_pkg::ACC_W-1:0]   r_p2;
    logic signed [mbl_pkg::ACC_W-1:0]   r_p3;
    logic signed [mbl_pkg::ACC_W-1:0]   r_s1;
    logic signed [mbl_pkg::ACC_W-1:0]   r_s2;
    logic signed [mbl_pkg::ACC_W-1:0]   acc;
    logic signed [Q_W-1:0]              q;

    // x and x2 share the a0 weight, so add them before the multiply
    assign xs = $signed({i_x[mbl_pkg::SAMPLE_W-1], i_x})
              + $signed({i_hist.x2[mbl_pkg::SAMPLE_W-1], i_hist.x2});

    assign m0 = xs * $signed(i_coefs.a0);
    assign m1 = $signed(i_hist.x1) * $signed(i_coefs.a1);
    assign m2 = $signed(i_hist.y1) * $signed(i_coefs.b1);
    assign m3 = $signed(i_hist.y2) * $signed(i_coefs.b2);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0 <= mbl_pkg::ACC_W'(m0);
            r_p1 <= mbl_pkg::ACC_W'(m1);
            r_p2 <= mbl_pkg::ACC_W'(m2);
            r_p3 <= mbl_pkg::ACC_W'(m3);
            r_s1 <= r_p0 + r_p1 + ROUND_BIAS;
            r_s2 <= r_p2 + r_p3;
        end
    end

    // feedback terms are subtracted; floor shift after the half-lsb bias
    assign acc = r_s1 - r_s2;
    assign q   = acc[mbl_pkg::ACC_W-1:mbl_pkg::FRAC_W];

    always_comb begin
        if (q > SAT_MAX) begin
            o_y = SAT_MAX[mbl_pkg::SAMPLE_W-1:0];
        end else if (q < SAT_MIN) begin
            o_y = SAT_MIN[mbl_pkg::SAMPLE_W-1:0];
        end else begin
            o_y = q[mbl_pkg::SAMPLE_W-1:0];
        end
    end

endmodule

>>> hdl/multichannel_biquad_lowpass_unit.sv
// top level of the multichannel biquad lowpass: history memory, hazard interlock, output stage
// depends on mbl_pkg and mbl_mac
//
//   channel   direction  handshake            payload
//   input     in         i_valid / o_stall    i_opcode, i_chan_index, i_sample_in
//   output    out        o_valid / i_stall    o_chan_out, o_sample_out
//   config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// one request per cycle when channels interleave and no stall freezes the pipeline; each
// result is registered through stages a, b, c and r_out; a request for a channel still in
// any of the 3 compute stages is held, since its y1 exists only after round and saturate
// a clear request is held until the compute stages are empty, then drops all valid marks
// i_stall with a result waiting freezes the whole pipeline
// reset clears valid marks and stage flags; the history memory needs no clearing pass
module multichannel_biquad_lowpass_unit #(
    parameter int CHANNELS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_opcode,
    input  logic [mbl_pkg::CH_W-1:0]            i_chan_index,
    input  logic signed [mbl_pkg::SAMPLE_W-1:0] i_sample_in,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [mbl_pkg::CH_W-1:0]            o_chan_out,
    output logic signed [mbl_pkg::SAMPLE_W-1:0] o_sample_out,
    input  logic                                i_cfg_we,
    input  logic [mbl_pkg::CFG_AW-1:0]          i_cfg_index,
    input  logic [mbl_pkg::COEF_W-1:0]          i_cfg_data
);

    localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    mbl_pkg::t_coefs                r_coefs;
    mbl_pkg::t_hist                 r_hist_mem [CHANNELS];
    mbl_pkg::t_hist                 r_rd_data;
    mbl_pkg::t_hist                 a_hist;
    mbl_pkg::t_hist                 wr_hist;
    logic [CHANNELS-1:0]            r_hist_vld;

    logic                           r_a_vld;
    logic                           r_b_vld;
    logic                           r_c_vld;
    logic [mbl_pkg::CH_W-1:0]       r_a_ch;
    logic [mbl_pkg::CH_W-1:0]       r_b_ch;
    logic [mbl_pkg::CH_W-1:0]       r_c_ch;
    logic [mbl_pkg::SAMPLE_W-1:0]   r_a_x;
    logic [mbl_pkg::SAMPLE_W-1:0]   r_b_x;
    logic [mbl_pkg::SAMPLE_W-1:0]   r_c_x;
    logic [mbl_pkg::SAMPLE_W-1:0]   r_b_x1;
    logic [mbl_pkg::SAMPLE_W-1:0]   r_c_x1;
    logic [mbl_pkg::SAMPLE_W-1:0]   r_b_y1;
    logic [mbl_pkg::SAMPLE_W-1:0]   r_c_y1;

    logic                           r_out_vld;
    logic [mbl_pkg::CH_W-1:0]       r_out_ch;
    logic signed [mbl_pkg::SAMPLE_W-1:0] r_out_y;

    logic                           adv;
    logic                           hazard;
    logic                           busy;
    logic                           accept;
    logic                           in_ok;
    logic                           acc_filter;
    logic                           acc_clear;
    logic [CH_AW-1:0]               in_addr;
    logic [CH_AW-1:0]               a_addr;
    logic [CH_AW-1:0]               c_addr;
    logic signed [mbl_pkg::SAMPLE_W-1:0] c_y;

    // ---------------- control ----------------
    assign adv    = !r_out_vld || !i_stall;
    assign busy   = r_a_vld || r_b_vld || r_c_vld;
    assign hazard = (mbl_pkg::t_opcode'(i_opcode) == mbl_pkg::OP_CLEAR) ? busy :
                    ((r_a_vld && (r_a_ch == i_chan_index)) ||
                     (r_b_vld && (r_b_ch == i_chan_index)) ||
                     (r_c_vld && (r_c_ch == i_chan_index)));
    assign o_stall = !adv || hazard;
    assign accept  = i_valid && !o_stall;

    assign in_ok      = ({{(32 - mbl_pkg::CH_W){1'b0}}, i_chan_index} < 32'(CHANNELS));
    assign acc_filter = accept && (mbl_pkg::t_opcode'(i_opcode) == mbl_pkg::OP_FILTER) && in_ok;
    assign acc_clear  = accept && (mbl_pkg::t_opcode'(i_opcode) == mbl_pkg::OP_CLEAR);

    assign in_addr = CH_AW'(i_chan_index);
    assign a_addr  = CH_AW'(r_a_ch);
    assign c_addr  = CH_AW'(r_c_ch);

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= '0;
        end else if (i_cfg_we) begin
            case (mbl_pkg::t_cfg_index'(i_cfg_index))
                mbl_pkg::REG_GAIN_A0:     r_coefs.a0 <= i_cfg_data;
                mbl_pkg::REG_GAIN_A1:     r_coefs.a1 <= i_cfg_data;
                mbl_pkg::REG_FEEDBACK_B1: r_coefs.b1 <= i_cfg_data;
                mbl_pkg::REG_FEEDBACK_B2: r_coefs.b2 <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ---------------- history memory ----------------
    assign wr_hist = '{x1: r_c_x, x2: r_c_x1, y1: c_y, y2: r_c_y1};

    always_ff @(posedge i_clk) begin
        if (acc_filter) begin
            r_rd_data <= r_hist_mem[in_addr];
        end
        if (adv && r_c_vld) begin
            r_hist_mem[c_addr] <= wr_hist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_vld <= '0;
        end else if (acc_clear) begin
            r_hist_vld <= '0;
        end else if (adv && r_c_vld) begin
            r_hist_vld[c_addr] <= 1'b1;
        end
    end

    // a channel never written since reset or clear reads as all zero
    assign a_hist = r_hist_vld[a_addr] ? r_rd_data : '0;

    // ---------------- compute stages ----------------
    mbl_mac u_mac (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_x     ($signed(r_a_x)),
        .i_hist  (a_hist),
        .i_coefs (r_coefs),
        .o_y     (c_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_a_vld   <= acc_filter;
            r_b_vld   <= r_a_vld;
            r_c_vld   <= r_b_vld;
            r_out_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (accept) begin
                r_a_ch <= i_chan_index;
                r_a_x  <= i_sample_in;
            end
            r_b_ch   <= r_a_ch;
            r_b_x    <= r_a_x;
            r_b_x1   <= a_hist.x1;
            r_b_y1   <= a_hist.y1;
            r_c_ch   <= r_b_ch;
            r_c_x    <= r_b_x;
            r_c_x1   <= r_b_x1;
            r_c_y1   <= r_b_y1;
            r_out_ch <= r_c_ch;
            r_out_y  <= c_y;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_chan_out   = r_out_ch;
    assign o_sample_out = r_out_y;

`ifndef SYNTH
    // interlock keeps a channel in at most one compute stage
    a_no_dup_bc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_vld && r_c_vld) |-> (r_b_ch != r_c_ch))
        else $error("same channel in two compute stages");

    a_no_dup_ac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_vld && r_c_vld) |-> (r_a_ch != r_c_ch))
        else $error("same channel in two compute stages");

    a_clear_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_clear |-> !(r_a_vld || r_b_vld || r_c_vld))
        else $error("clear taken with filter requests in flight");

    a_clear_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_clear |=> (r_hist_vld == '0))
        else $error("valid marks not dropped by clear");

    a_commit_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_c_vld) |=> r_hist_vld[$past(c_addr)])
        else $error("committed channel not marked valid");
`endif

endmodule

>>> bench/biquad_output_check.sv
// result checker for the multichannel biquad lowpass unit: keeps its own coefficients and
// per-channel histories, predicts every filtered sample and compares it with the output channel
// depends on mbl_pkg
module biquad_output_check #(
    parameter int CHANNELS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_req_valid,
    input  logic                                i_req_stall,
    input  logic                                i_opcode,
    input  logic [mbl_pkg::CH_W-1:0]            i_chan_index,
    input  logic signed [mbl_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic                                i_res_valid,
    input  logic                                i_res_stall,
    input  logic [mbl_pkg::CH_W-1:0]            i_chan_out,
    input  logic signed [mbl_pkg::SAMPLE_W-1:0] i_sample_out,
    input  logic                                i_cfg_we,
    input  logic [mbl_pkg::CFG_AW-1:0]          i_cfg_index,
    input  logic [mbl_pkg::COEF_W-1:0]          i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import mbl_pkg::*;

    localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint SAT_LO = -(longint'(1) <<< (SAMPLE_W - 1));
    localparam longint ROUND_HALF = longint'(1) <<< (FRAC_W - 1);

    typedef struct packed {
        logic [CH_W-1:0]            chan;
        logic signed [SAMPLE_W-1:0] sample;
    } t_filtered;

    logic signed [COEF_W-1:0]   coef_a0;
    logic signed [COEF_W-1:0]   coef_a1;
    logic signed [COEF_W-1:0]   coef_b1;
    logic signed [COEF_W-1:0]   coef_b2;
    logic signed [SAMPLE_W-1:0] x_one [CHANNELS];
    logic signed [SAMPLE_W-1:0] x_two [CHANNELS];
    logic signed [SAMPLE_W-1:0] y_one [CHANNELS];
    logic signed [SAMPLE_W-1:0] y_two [CHANNELS];
    logic                       hist_live [CHANNELS];
    t_filtered                  awaited_samples [$];

    task report_mismatch(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0d, predicted %0d", $time, what, got, want);
        o_fail_count++;
    endtask

    // direct form I step on one channel, shifts that channel's history
    function automatic t_filtered lowpass_step(logic [CH_W-1:0] ch,
                                               logic signed [SAMPLE_W-1:0] x);
        longint    xn;
        longint    x1;
        longint    x2;
        longint    y1;
        longint    y2;
        longint    acc;
        longint    q;
        t_filtered r;
        xn = longint'(x);
        x1 = 0;
        x2 = 0;
        y1 = 0;
        y2 = 0;
        if (hist_live[ch]) begin
            x1 = longint'(x_one[ch]);
            x2 = longint'(x_two[ch]);
            y1 = longint'(y_one[ch]);
            y2 = longint'(y_two[ch]);
        end
        acc = longint'(coef_a0) * (xn + x2) + longint'(coef_a1) * x1
            - longint'(coef_b1) * y1 - longint'(coef_b2) * y2;
        // round half up, then clamp to the sample range
        q = (acc + ROUND_HALF) >>> FRAC_W;
        if (q > SAT_HI) begin
            q = SAT_HI;
        end else if (q < SAT_LO) begin
            q = SAT_LO;
        end
        x_two[ch] = x1[SAMPLE_W-1:0];
        x_one[ch] = x;
        y_two[ch] = y1[SAMPLE_W-1:0];
        y_one[ch] = q[SAMPLE_W-1:0];
        hist_live[ch] = 1'b1;
        r.chan = ch;
        r.sample = q[SAMPLE_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_filtered want;
        if (!i_rst_n) begin
            o_fail_count = 0;
            coef_a0 = '0;
            coef_a1 = '0;
            coef_b1 = '0;
            coef_b2 = '0;
            foreach (hist_live[i]) begin
                hist_live[i] = 1'b0;
                x_one[i] = '0;
                x_two[i] = '0;
                y_one[i] = '0;
                y_two[i] = '0;
            end
            awaited_samples.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    REG_GAIN_A0:     coef_a0 = i_cfg_data;
                    REG_GAIN_A1:     coef_a1 = i_cfg_data;
                    REG_FEEDBACK_B1: coef_b1 = i_cfg_data;
                    REG_FEEDBACK_B2: coef_b2 = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_req_valid && !i_req_stall) begin
                if (i_opcode == OP_CLEAR) begin
                    foreach (hist_live[i]) hist_live[i] = 1'b0;
                end else if (int'(i_chan_index) < CHANNELS) begin
                    awaited_samples.push_back(lowpass_step(i_chan_index, i_sample_in));
                end
            end
            if (i_res_valid && !i_res_stall) begin
                if (awaited_samples.size() == 0) begin
                    report_mismatch("unrequested result on channel", i_chan_out, -1);
                end else begin
                    want = awaited_samples.pop_front();
                    if (i_chan_out !== want.chan) begin
                        report_mismatch("chan_out", i_chan_out, want.chan);
                    end
                    if (i_sample_out !== want.sample) begin
                        report_mismatch("sample_out", $signed(i_sample_out), want.sample);
                    end
                end
            end
        end
        o_pending = awaited_samples.size();
    end

endmodule

>>> bench/multichannel_biquad_lowpass_unit_tb.sv
// testbench top for the multichannel biquad lowpass unit: clock, reset, coefficient
// settings, request and result traffic with random idling; verdict from biquad_output_check
// depends on mbl_pkg, multichannel_biquad_lowpass_unit and biquad_output_check
module multichannel_biquad_lowpass_unit_tb;
    import mbl_pkg::*;

    localparam int NUM_SETTINGS = 8;
    localparam int RANDOM_PER_SETTING = 175;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    logic                       i_opcode;
    logic [CH_W-1:0]            i_chan_index;
    logic signed [SAMPLE_W-1:0] i_sample_in;
    logic                       o_valid;
    logic                       i_stall;
    logic [CH_W-1:0]            o_chan_out;
    logic signed [SAMPLE_W-1:0] o_sample_out;
    logic                       i_cfg_we;
    logic [CFG_AW-1:0]          i_cfg_index;
    logic [COEF_W-1:0]          i_cfg_data;

    int                         fail_count;
    int                         pending;
    int                         requests_sent;
    int                         clears_sent;
    logic                       idle_on;
    logic [CH_W-1:0]            last_chan;
    logic signed [SAMPLE_W-1:0] extreme_samples [5];

    always #6 i_clk = ~i_clk;

    multichannel_biquad_lowpass_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_opcode     (i_opcode),
        .i_chan_index (i_chan_index),
        .i_sample_in  (i_sample_in),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_chan_out   (o_chan_out),
        .o_sample_out (o_sample_out),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    biquad_output_check u_output_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_stall  (o_stall),
        .i_opcode     (i_opcode),
        .i_chan_index (i_chan_index),
        .i_sample_in  (i_sample_in),
        .i_res_valid  (o_valid),
        .i_res_stall  (i_stall),
        .i_chan_out   (o_chan_out),
        .i_sample_out (o_sample_out),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    task automatic push_request(t_opcode op, logic [CH_W-1:0] ch,
                                logic signed [SAMPLE_W-1:0] s);
        int gap;
        gap = idle_on ? $urandom_range(0, 13) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            i_opcode <= 1'($urandom_range(0, 1));
            i_chan_index <= CH_W'($urandom_range(0, 7));
            i_sample_in <= SAMPLE_W'($urandom);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_opcode <= op;
        i_chan_index <= ch;
        i_sample_in <= s;
        do @(posedge i_clk); while (!(i_valid && !o_stall));
        if (op == OP_CLEAR) begin
            clears_sent++;
        end else begin
            requests_sent++;
        end
        last_chan = ch;
    endtask

    task automatic set_coefs(logic [COEF_W-1:0] a0, logic [COEF_W-1:0] a1,
                             logic [COEF_W-1:0] b1, logic [COEF_W-1:0] b2);
        logic [COEF_W-1:0] vals [4];
        vals = '{a0, a1, b1, b2};
        for (int i = 0; i < 4; i++) begin
            @(negedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_index <= t_cfg_index'(i);
            i_cfg_data <= vals[i];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait out every predicted result, plus slack for a clear still in flight
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (pending == 0);
        repeat (8) @(negedge i_clk);
    endtask

    function automatic logic [COEF_W-1:0] modest_coef();
        // within about +-2.0 in Q3.28
        return $urandom_range(0, 32'h3FFF_FFFF) - 32'h2000_0000;
    endfunction

    // result side: random hold-offs, quiet stretches, and now and then a long back-up
    initial begin : result_drain
        int hold;
        int taken;
        taken = 0;
        i_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (taken % 300 == 150) begin
                hold = 90;
            end else if ((taken / 60) % 3 == 0) begin
                hold = 0;
            end else begin
                hold = $urandom_range(0, 13);
            end
            repeat (hold) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
            end
            @(negedge i_clk);
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && !i_stall));
            taken++;
        end
    end

    initial begin
        #(12 * 400000);
        $display("FAIL");
        $finish;
    end

    initial begin
        int                         pick;
        logic [CH_W-1:0]            ch;
        logic signed [SAMPLE_W-1:0] s;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_opcode = OP_FILTER;
        i_chan_index = '0;
        i_sample_in = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_GAIN_A0;
        i_cfg_data = '0;
        idle_on = 1'b0;
        last_chan = '0;
        requests_sent = 0;
        clears_sent = 0;
        extreme_samples = '{24'sh7F_FFFF, -24'sh80_0000, 24'sd0, -24'sd1, 24'sd1};
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // all four taps live: a0 = 0.5, a1 = -1.0, b1 = 0.5, b2 = -0.25
        set_coefs(32'h0800_0000, -32'sh1000_0000, 32'h0800_0000, -32'sh0400_0000);
        push_request(OP_FILTER, 3'd0, 24'sh7F_FFFF);
        push_request(OP_FILTER, 3'd0, 24'sh7F_FFFF);
        push_request(OP_FILTER, 3'd0, -24'sh80_0000);
        push_request(OP_FILTER, 3'd0, -24'sh80_0000);
        push_request(OP_FILTER, 3'd0, 24'sd0);
        push_request(OP_FILTER, 3'd7, -24'sh80_0000);
        push_request(OP_FILTER, 3'd7, 24'sd1);
        push_request(OP_FILTER, 3'd7, -24'sd1);
        // odd samples times one half land exactly on the rounding tie
        push_request(OP_FILTER, 3'd3, 24'sd1);
        push_request(OP_FILTER, 3'd3, -24'sd1);
        push_request(OP_FILTER, 3'd3, 24'sd1);
        push_request(OP_CLEAR, 3'd5, 24'sh5A_5A5A);
        // history must read as zero after the clear
        push_request(OP_FILTER, 3'd0, 24'sh7F_FFFF);
        push_request(OP_FILTER, 3'd7, 24'sd3);
        push_request(OP_FILTER, 3'd1, 24'sd1);
        push_request(OP_FILTER, 3'd2, -24'sd1);
        push_request(OP_FILTER, 3'd4, 24'sh55_5555);
        push_request(OP_FILTER, 3'd5, -24'sh2A_AAAB);
        push_request(OP_FILTER, 3'd6, 24'sh7F_FFFF);
        push_request(OP_CLEAR, 3'd2, -24'sd1);
        push_request(OP_FILTER, 3'd2, -24'sh80_0000);

        for (int phase = 0; phase < NUM_SETTINGS; phase++) begin
            if (phase > 0) begin
                drain();
                case (phase)
                    // butterworth lowpass near fs/24
                    1: set_coefs(32'sd3865700, 32'sd7731400, -32'sd438362000, 32'sd185385000);
                    2: set_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
                    3: set_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
                    4: set_coefs(32'h0800_0000, 32'h0, 32'h0, 32'h0);
                    5: set_coefs($urandom, $urandom, $urandom, $urandom);
                    6: set_coefs(modest_coef(), modest_coef(), modest_coef(), modest_coef());
                    default: set_coefs(32'h0, 32'h0, 32'h0, 32'h0);
                endcase
            end
            for (int n = 0; n < RANDOM_PER_SETTING; n++) begin
                if (n % 40 == 0) idle_on = ($urandom_range(0, 2) != 0);
                pick = $urandom_range(0, 99);
                if (pick < 3) begin
                    ch = CH_W'($urandom_range(0, 7));
                    s = SAMPLE_W'($urandom);
                    push_request(OP_CLEAR, ch, s);
                end else begin
                    // repeat a channel now and then so the same-channel interlock gets hit
                    ch = ($urandom_range(0, 3) == 0) ? last_chan : 3'($urandom_range(0, 7));
                    if ($urandom_range(0, 7) == 0) begin
                        s = extreme_samples[$urandom_range(0, 4)];
                    end else begin
                        s = SAMPLE_W'($urandom);
                    end
                    push_request(OP_FILTER, ch, s);
                end
            end
        end
        drain();

        $display("ran %0d filter requests and %0d clears over %0d coefficient settings",
                 requests_sent, clears_sent, NUM_SETTINGS);
        $display("mismatches seen: %0d", fail_count);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
